// File: hdl/dsa_pkg.sv
package dsa_pkg;

    localparam int SLOTS      = 64;
    localparam int SLOT_W     = 6;                 // slot index width
    localparam int DL_W       = 7;                 // clamped deadline, 0..SLOTS
    localparam int CNT_W      = 7;                 // task ordinal, 1..SLOTS+1
    localparam int PEN_W      = 16;
    localparam int SUM_W      = 32;
    localparam int CELL_W     = 8;                 // slots held by one cell
    localparam int CELL_SEL_W = 3;                 // bits of slot picking the bit in a cell
    localparam int CELLS      = SLOTS / CELL_W;
    localparam int CELL_IDX_W = SLOT_W - CELL_SEL_W;

    // Search results handed from the cell above to the cell below.
    typedef struct packed {
        logic              ontime_hit;
        logic [SLOT_W-1:0] ontime_slot;
        logic              free_hit;
        logic [SLOT_W-1:0] free_slot;
    } dsa_chain_t;

    // Broadcast to every cell while a task is being placed.
    typedef struct packed {
        logic              new_set;     // treat the map as empty
        logic              update;      // commit this cycle
        logic              occupy;      // mark slot as taken
        logic [SLOT_W-1:0] slot;
        logic [DL_W-1:0]   deadline;
    } dsa_ctrl_t;

endpackage

// File: hdl/dsa_cell.sv
module dsa_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [dsa_pkg::CELL_IDX_W-1:0]      cell_index,
    input  dsa_pkg::dsa_ctrl_t                  ctrl,
    input  dsa_pkg::dsa_chain_t                 chain_in,
    output dsa_pkg::dsa_chain_t                 chain_out
);
    import dsa_pkg::*;

    logic [CELL_W-1:0] bits_reg;
    logic [CELL_W-1:0] bits_next;
    logic [CELL_W-1:0] bits_eff;
    dsa_chain_t        local_res;

    assign bits_eff = ctrl.new_set ? '0 : bits_reg;

    // Highest free slot in this cell, overall and below the deadline.
    always_comb
    begin
        logic [SLOT_W-1:0] idx;
        local_res = '0;
        idx       = '0;
        for (int j = 0; j < CELL_W; j++)
        begin
            idx = {cell_index, CELL_SEL_W'(j)};
            if (!bits_eff[j])
            begin
                local_res.free_hit  = 1'b1;
                local_res.free_slot = idx;
                if ({1'b0, idx} < ctrl.deadline)
                begin
                    local_res.ontime_hit  = 1'b1;
                    local_res.ontime_slot = idx;
                end
            end
        end
    end

    // Higher cells win.
    always_comb
    begin
        chain_out = chain_in;
        if (!chain_in.ontime_hit)
        begin
            chain_out.ontime_hit  = local_res.ontime_hit;
            chain_out.ontime_slot = local_res.ontime_slot;
        end
        if (!chain_in.free_hit)
        begin
            chain_out.free_hit  = local_res.free_hit;
            chain_out.free_slot = local_res.free_slot;
        end
    end

    always_comb
    begin
        bits_next = bits_eff;
        if (ctrl.occupy && (ctrl.slot[SLOT_W-1:CELL_SEL_W] == cell_index))
        begin
            bits_next = bits_eff | (CELL_W'(1) << ctrl.slot[CELL_SEL_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
        end
        else if (ctrl.update)
        begin
            bits_reg <= bits_next;
        end
    end

endmodule

// File: hdl/deadline_slot_allocator_core.sv
// A task waits in the input stage, then is placed and loaded into the output register.
// Throughput: one task per cycle while results are taken; the slot search
// ripples combinationally through the row of cells during placement.
// Reset (async, active low): slot map empty, internal late start 64, total 0,
// task ordinal 1, no task in flight, no result pending.
module deadline_slot_allocator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          new_set,
    input  logic [7:0]                    deadline,
    input  logic [dsa_pkg::PEN_W-1:0]     penalty,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dsa_pkg::CNT_W-1:0]     task_number,
    output logic [dsa_pkg::SLOT_W-1:0]    slot,
    output logic                          on_time,
    output logic                          rejected,
    output logic [dsa_pkg::DL_W-1:0]      late_start,
    output logic [dsa_pkg::SUM_W-1:0]     penalty_total
);
    import dsa_pkg::*;

    // Input stage: one task waiting for placement.
    logic              busy_reg;
    logic              busy_next;
    logic              new_set_reg;
    logic [DL_W-1:0]   deadline_reg;
    logic [PEN_W-1:0]  penalty_reg;

    // Set-wide totals (the slot map itself lives in the cells).
    logic [DL_W-1:0]   late_reg;
    logic [DL_W-1:0]   late_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // Output register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CNT_W-1:0]  task_number_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              on_time_reg;
    logic              rejected_reg;
    logic [DL_W-1:0]   late_start_reg;
    logic [SUM_W-1:0]  total_reg;

    logic              in_xfer;
    logic              place;        // placement happens at this edge
    logic [DL_W-1:0]   deadline_clamp;

    logic [DL_W-1:0]   late_eff;
    logic [SUM_W-1:0]  sum_eff;
    logic [CNT_W-1:0]  count_eff;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_sat;

    logic              is_rejected;
    logic              is_ontime;
    logic              is_late;
    logic [SLOT_W-1:0] chosen_slot;

    dsa_ctrl_t         ctrl;
    dsa_chain_t        chain [CELLS:0];

    // The placement stage frees up when its result can be loaded into the
    // output register; a new task may enter on that same edge.
    assign place    = busy_reg && (!out_valid_reg || !out_stall);
    assign in_stall = busy_reg && !place;
    assign in_xfer  = in_valid && !in_stall;

    // Deadlines past the end of the map are clamped to SLOTS, the end of the map.
    assign deadline_clamp = (deadline > 8'(SLOTS)) ? DL_W'(SLOTS) : deadline[DL_W-1:0];

    // A new set starts from the reset totals.
    assign late_eff  = new_set_reg ? DL_W'(SLOTS) : late_reg;
    assign sum_eff   = new_set_reg ? '0 : sum_reg;
    assign count_eff = new_set_reg ? CNT_W'(1) : count_reg;

    // Cell chain: top cell starts with nothing found; results ripple down.
    assign chain[CELLS] = '0;

    generate
        for (genvar g = 0; g < CELLS; g++)
        begin : g_cell
            dsa_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_index (CELL_IDX_W'(g)),
                .ctrl       (ctrl),
                .chain_in   (chain[g+1]),
                .chain_out  (chain[g])
            );
        end
    endgenerate

    // Below the lowest free slot everything is taken, so the latest free slot
    // under the deadline is the on-time pick; otherwise the highest free slot.
    assign is_rejected = !chain[0].free_hit;
    assign is_ontime   = !is_rejected && chain[0].ontime_hit;
    assign is_late     = !is_rejected && !chain[0].ontime_hit;
    assign chosen_slot = is_ontime ? chain[0].ontime_slot : chain[0].free_slot;

    assign sum_wide = {1'b0, sum_eff} + {{(SUM_W+1-PEN_W){1'b0}}, penalty_reg};
    assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

    always_comb
    begin
        ctrl.new_set  = new_set_reg;
        ctrl.update   = place;
        ctrl.occupy   = !is_rejected;
        ctrl.slot     = chosen_slot;
        ctrl.deadline = deadline_reg;
    end

    always_comb
    begin
        late_next  = late_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        if (place)
        begin
            late_next  = is_late ? {1'b0, chain[0].free_slot} : late_eff;
            sum_next   = is_late ? sum_sat : sum_eff;
            count_next = is_rejected ? count_eff : count_eff + CNT_W'(1);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (place)
        begin
            busy_next = 1'b0;
        end
        if (in_xfer)
        begin
            busy_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (place)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            late_reg      <= DL_W'(SLOTS);
            sum_reg       <= '0;
            count_reg     <= CNT_W'(1);
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            late_reg      <= late_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            new_set_reg  <= new_set;
            deadline_reg <= deadline_clamp;
            penalty_reg  <= penalty;
        end
        if (place)
        begin
            task_number_reg <= count_eff;
            slot_reg        <= is_rejected ? '0 : chosen_slot;
            on_time_reg     <= is_ontime;
            rejected_reg    <= is_rejected;
            late_start_reg  <= late_next;
            total_reg       <= sum_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign task_number   = task_number_reg;
    assign slot          = slot_reg;
    assign on_time       = on_time_reg;
    assign rejected      = rejected_reg;
    assign late_start    = late_start_reg;
    assign penalty_total = total_reg;

endmodule
